[design/polygon_column_edge_crossings_macros.svh]
// Assertion macros shared by the column edge crossing checkers.
// No dependencies; the including module provides clk and arst_n.
`ifndef POLYGON_COLUMN_EDGE_CROSSINGS_MACROS_SVH
`define POLYGON_COLUMN_EDGE_CROSSINGS_MACROS_SVH

// Check cons in the same cycle as ante.
`define PCE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define PCE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/pce_pkg.sv]
// Shared types and constants for the polygon column edge crossing block.
// No dependencies.
package pce_pkg;

	localparam int MAX_VERTICES = 8;
	localparam int MIN_VERTICES = 3;
	localparam int VIDX_W = 3;
	localparam int CNT_W = 4;
	localparam int COORD_W = 16;
	localparam int FRAC_BITS = 8;
	localparam int COL_W = 5;
	localparam int EXT_W = COORD_W + 1;
	localparam int PROD_W = 2 * EXT_W;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_SWEEP = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [VIDX_W-1:0] vertex_index;
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic [COL_W-1:0] column_x;
	} pce_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] crossing_y;
		logic none_found;
		logic is_last;
	} pce_out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} pce_vertex_t;

	typedef struct packed {
		logic clear;
		logic ins_start;
		logic rd_en;
		logic [VIDX_W-1:0] rd_addr;
	} pce_sort_ctl_t;

	typedef struct packed {
		logic ins_done;
		logic [CNT_W-1:0] count;
	} pce_sort_sts_t;

endpackage

[design/pce_vertex_mem.sv]
// Vertex store: one write port, one read port with registered read data.
// Depends on pce_pkg.
module pce_vertex_mem import pce_pkg::*; (
	input logic clk,
	input logic we,
	input logic [VIDX_W-1:0] waddr,
	input pce_vertex_t wdata,
	input logic re,
	input logic [VIDX_W-1:0] raddr,
	output pce_vertex_t rdata
);

	pce_vertex_t mem_q [MAX_VERTICES];
	pce_vertex_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/pce_divider.sv]
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pce_pkg.
module pce_divider import pce_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [PROD_W-1:0] num,
	input logic signed [EXT_W-1:0] den,
	output logic done,
	output logic signed [EXT_W-1:0] quo
);

	localparam int MAG_W = 2 * COORD_W;
	localparam int STEP_W = $clog2(MAG_W + 1);

	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [COORD_W-1:0] rem_q;
	logic [COORD_W-1:0] dmag_q;
	logic [MAG_W-1:0] quo_q;
	logic neg_q;

	logic [PROD_W-1:0] nmag;
	logic [EXT_W-1:0] dmag;
	logic [COORD_W:0] trial;
	logic fit;
	logic signed [EXT_W-1:0] qmag;

	assign nmag = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
	assign dmag = den[EXT_W-1] ? EXT_W'(-den) : EXT_W'(den);
	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign fit = trial >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= STEP_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= nmag[MAG_W-1:0];
			dmag_q <= dmag[COORD_W-1:0];
			rem_q <= '0;
			neg_q <= num[PROD_W-1] ^ den[EXT_W-1];
		end else if (busy_q) begin
			rem_q <= fit ? COORD_W'(trial - {1'b0, dmag_q}) : trial[COORD_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], fit};
		end
	end

	assign qmag = signed'(quo_q[EXT_W-1:0]);
	assign quo = neg_q ? -qmag : qmag;
	assign done = done_q;

endmodule

[design/pce_sorter.sv]
// Sorted crossing list: memory plus insertion sequencer that shifts from the tail.
// Depends on pce_pkg.
module pce_sorter import pce_pkg::*; (
	input logic clk,
	input logic arst_n,
	input pce_sort_ctl_t ctl,
	input logic signed [COORD_W-1:0] ins_value,
	output pce_sort_sts_t sts,
	output logic signed [COORD_W-1:0] rd_data
);

	localparam logic [1:0] SS_IDLE = 2'd0;
	localparam logic [1:0] SS_CMP = 2'd1;
	localparam logic [1:0] SS_PUT = 2'd2;

	logic signed [COORD_W-1:0] mem_q [MAX_VERTICES];
	logic signed [COORD_W-1:0] rd_q;
	logic [1:0] st_q;
	logic [1:0] st_d;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] k_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic signed [COORD_W-1:0] val_q;
	logic done_d;
	logic done_q;

	logic re;
	logic [VIDX_W-1:0] ra;
	logic we;
	logic [VIDX_W-1:0] wa;
	logic signed [COORD_W-1:0] wd;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] k_m2;

	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign k_m2 = k_q - CNT_W'(2);

	always_comb begin
		st_d = st_q;
		k_d = k_q;
		cnt_d = cnt_q;
		done_d = 1'b0;
		re = 1'b0;
		ra = ctl.rd_addr;
		we = 1'b0;
		wa = '0;
		wd = val_q;
		case (st_q)
			SS_IDLE: begin
				if (ctl.clear) begin
					cnt_d = '0;
				end else if (ctl.ins_start) begin
					if (cnt_q == '0) begin
						we = 1'b1;
						wd = ins_value;
						cnt_d = CNT_W'(1);
						done_d = 1'b1;
					end else begin
						re = 1'b1;
						ra = cnt_m1[VIDX_W-1:0];
						k_d = cnt_q;
						st_d = SS_CMP;
					end
				end else if (ctl.rd_en) begin
					re = 1'b1;
				end
			end
			SS_CMP: begin
				we = 1'b1;
				wa = k_q[VIDX_W-1:0];
				if (rd_q >= val_q) begin
					wd = rd_q;
					k_d = k_q - CNT_W'(1);
					if (k_q == CNT_W'(1)) begin
						st_d = SS_PUT;
					end else begin
						re = 1'b1;
						ra = k_m2[VIDX_W-1:0];
					end
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
					done_d = 1'b1;
					st_d = SS_IDLE;
				end
			end
			SS_PUT: begin
				we = 1'b1;
				cnt_d = cnt_q + CNT_W'(1);
				done_d = 1'b1;
				st_d = SS_IDLE;
			end
			default: begin
				st_d = SS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SS_IDLE;
			cnt_q <= '0;
			k_q <= '0;
			done_q <= 1'b0;
		end else begin
			st_q <= st_d;
			cnt_q <= cnt_d;
			k_q <= k_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins_start && st_q == SS_IDLE) begin
			val_q <= ins_value;
		end
		if (we) begin
			mem_q[wa] <= wd;
		end
		if (re) begin
			rd_q <= mem_q[ra];
		end
	end

	assign sts.ins_done = done_q;
	assign sts.count = cnt_q;
	assign rd_data = rd_q;

endmodule

[design/polygon_column_edge_crossings.sv]
// Polygon column edge crossings: top level with sweep sequencer and output register.
// Depends on pce_pkg, pce_vertex_mem, pce_divider and pce_sorter.
//
// Input channel (in_valid/in_ready/in_data) carries one request per transfer.
// A vertex write (req_type 0) fills one vertex slot and leaves in_ready high.
// A sweep (req_type 1) walks every polygon edge for the named column and
// returns the crossings in ascending y, the last flagged is_last; with no
// crossing it returns one result flagged none_found and is_last.
// The serial divide for each crossing edge dominates the time a sweep takes.
// One request is worked on at a time; in_ready is high only between sweeps.
// The output register holds a result until out_ready; the sequencer stalls
// on it, and the next request is taken while the last result still waits.
// cfg_wr_en/cfg_wr_data set vertex_count (clamped to 3..8); the user must
// write it only when idle, and the block itself does not enforce this.
// Reset clears control state and sets vertex_count to 3; vertex slots are
// undefined until written.
module polygon_column_edge_crossings import pce_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [CNT_W-1:0] cfg_wr_data,
	input logic in_valid,
	output logic in_ready,
	input pce_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output pce_out_t out_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LOADJ = 4'd1;
	localparam logic [3:0] S_RD = 4'd2;
	localparam logic [3:0] S_EDGE = 4'd3;
	localparam logic [3:0] S_MUL = 4'd4;
	localparam logic [3:0] S_DIV_GO = 4'd5;
	localparam logic [3:0] S_DIV_WAIT = 4'd6;
	localparam logic [3:0] S_INS_GO = 4'd7;
	localparam logic [3:0] S_INS_WAIT = 4'd8;
	localparam logic [3:0] S_ADV = 4'd9;
	localparam logic [3:0] S_EMIT = 4'd10;
	localparam logic [3:0] S_ENONE = 4'd11;
	localparam logic [3:0] S_ERD = 4'd12;
	localparam logic [3:0] S_EWAIT = 4'd13;

	logic [3:0] st_q;
	logic [3:0] st_d;
	logic [CNT_W-1:0] vcount_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] n_use;
	logic [VIDX_W-1:0] i_q;
	logic [VIDX_W-1:0] i_d;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] k_d;
	logic signed [EXT_W-1:0] xc_q;
	pce_vertex_t prev_q;
	logic signed [EXT_W-1:0] dx_q;
	logic signed [EXT_W-1:0] dy_q;
	logic signed [EXT_W-1:0] den_q;
	logic signed [EXT_W-1:0] yi_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [COORD_W-1:0] cross_q;
	logic out_valid_q;
	pce_out_t out_q;

	logic in_xfer;
	logic slot_free;
	logic load_out;
	pce_out_t load_val;
	logic [CNT_W-1:0] n_m1;
	logic [CNT_W-1:0] cnt_m1;

	logic vm_we;
	logic vm_re;
	logic [VIDX_W-1:0] vm_raddr;
	pce_vertex_t vm_wdata;
	pce_vertex_t vm_rdata;

	logic div_start;
	logic div_done;
	logic signed [EXT_W-1:0] div_quo;

	pce_sort_ctl_t sort_ctl;
	pce_sort_sts_t sort_sts;
	logic signed [COORD_W-1:0] sort_rd;

	logic signed [EXT_W-1:0] xi;
	logic signed [EXT_W-1:0] yi;
	logic signed [EXT_W-1:0] xj;
	logic signed [EXT_W-1:0] yj;
	logic in_span;
	logic signed [EXT_W-1:0] y_sum;

	assign in_ready = (st_q == S_IDLE);
	assign in_xfer = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	assign n_use = (vcount_q < CNT_W'(MIN_VERTICES)) ? CNT_W'(MIN_VERTICES) :
		(vcount_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_q;
	assign n_m1 = n_q - CNT_W'(1);
	assign cnt_m1 = sort_sts.count - CNT_W'(1);

	assign xi = EXT_W'(vm_rdata.x);
	assign yi = EXT_W'(vm_rdata.y);
	assign xj = EXT_W'(prev_q.x);
	assign yj = EXT_W'(prev_q.y);
	assign in_span = (xi != xj) &&
		((xi <= xc_q && xc_q <= xj) || (xj <= xc_q && xc_q <= xi));
	assign y_sum = yi_q + div_quo;

	assign vm_wdata.x = in_data.vertex_x;
	assign vm_wdata.y = in_data.vertex_y;
	assign vm_we = in_xfer && in_data.req_type == REQ_WRITE;

	always_comb begin
		st_d = st_q;
		i_d = i_q;
		k_d = k_q;
		vm_re = 1'b0;
		vm_raddr = i_q;
		div_start = 1'b0;
		sort_ctl = '0;
		sort_ctl.rd_addr = k_q[VIDX_W-1:0];
		load_out = 1'b0;
		load_val.crossing_y = sort_rd;
		load_val.none_found = 1'b0;
		load_val.is_last = (k_q == cnt_m1);
		case (st_q)
			S_IDLE: begin
				if (in_xfer && in_data.req_type == REQ_SWEEP) begin
					vm_re = 1'b1;
					vm_raddr = VIDX_W'(n_use - CNT_W'(1));
					sort_ctl.clear = 1'b1;
					st_d = S_LOADJ;
				end
			end
			S_LOADJ: begin
				i_d = '0;
				st_d = S_RD;
			end
			S_RD: begin
				vm_re = 1'b1;
				st_d = S_EDGE;
			end
			S_EDGE: begin
				st_d = in_span ? S_MUL : S_ADV;
			end
			S_MUL: begin
				st_d = S_DIV_GO;
			end
			S_DIV_GO: begin
				div_start = 1'b1;
				st_d = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					st_d = S_INS_GO;
				end
			end
			S_INS_GO: begin
				sort_ctl.ins_start = 1'b1;
				st_d = S_INS_WAIT;
			end
			S_INS_WAIT: begin
				if (sort_sts.ins_done) begin
					st_d = S_ADV;
				end
			end
			S_ADV: begin
				if ({1'b0, i_q} == n_m1) begin
					st_d = S_EMIT;
				end else begin
					i_d = i_q + VIDX_W'(1);
					st_d = S_RD;
				end
			end
			S_EMIT: begin
				k_d = '0;
				st_d = (sort_sts.count == '0) ? S_ENONE : S_ERD;
			end
			S_ENONE: begin
				load_val.crossing_y = '0;
				load_val.none_found = 1'b1;
				load_val.is_last = 1'b1;
				if (slot_free) begin
					load_out = 1'b1;
					st_d = S_IDLE;
				end
			end
			S_ERD: begin
				sort_ctl.rd_en = 1'b1;
				st_d = S_EWAIT;
			end
			S_EWAIT: begin
				if (slot_free) begin
					load_out = 1'b1;
					if (k_q == cnt_m1) begin
						st_d = S_IDLE;
					end else begin
						k_d = k_q + CNT_W'(1);
						st_d = S_ERD;
					end
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			vcount_q <= CNT_W'(MIN_VERTICES);
			i_q <= '0;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			i_q <= i_d;
			k_q <= k_d;
			if (cfg_wr_en) begin
				vcount_q <= cfg_wr_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && in_data.req_type == REQ_SWEEP) begin
			xc_q <= EXT_W'(in_data.column_x) << FRAC_BITS;
			n_q <= n_use;
		end
		if (st_q == S_LOADJ || st_q == S_EDGE) begin
			prev_q <= vm_rdata;
		end
		if (st_q == S_EDGE) begin
			dx_q <= xc_q - xi;
			dy_q <= yj - yi;
			den_q <= xj - xi;
			yi_q <= yi;
		end
		if (st_q == S_MUL) begin
			prod_q <= PROD_W'(dx_q) * PROD_W'(dy_q);
		end
		if (st_q == S_DIV_WAIT && div_done) begin
			cross_q <= y_sum[COORD_W-1:0];
		end
		if (load_out) begin
			out_q <= load_val;
		end
	end

	pce_vertex_mem u_vmem (
		.clk(clk),
		.we(vm_we),
		.waddr(in_data.vertex_index),
		.wdata(vm_wdata),
		.re(vm_re),
		.raddr(vm_raddr),
		.rdata(vm_rdata)
	);

	pce_divider u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(prod_q),
		.den(den_q),
		.done(div_done),
		.quo(div_quo)
	);

	pce_sorter u_sort (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(sort_ctl),
		.ins_value(cross_q),
		.sts(sort_sts),
		.rd_data(sort_rd)
	);

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

[design/pce_checker.sv]
// Port-level checker for polygon_column_edge_crossings, bound to the top level.
// Depends on pce_pkg and polygon_column_edge_crossings_macros.svh.
`include "polygon_column_edge_crossings_macros.svh"

module pce_checker import pce_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input pce_in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input pce_out_t out_data
);

	`PCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed before transfer")
	`PCE_ASSERT_NOW(a_none_last, out_valid && out_data.none_found, out_data.is_last && out_data.crossing_y == '0, "none_found result not last or nonzero")
	`PCE_ASSERT_NEXT(a_sweep_busy, in_valid && in_ready && in_data.req_type == REQ_SWEEP, !in_ready, "sweep transfer did not hold off input")
	`PCE_ASSERT_NEXT(a_write_ready, in_valid && in_ready && in_data.req_type == REQ_WRITE, in_ready, "vertex write stalled input")

endmodule

bind polygon_column_edge_crossings pce_checker u_pce_checker (.*);
